// ===== hdl/gpb_pkg.sv =====
// ----------------------------------------------------------------------------
// gpb_pkg - shared types and constants of the GPIO port bank
// Port count, pin width, command bit positions, register indexes and the
// request, response and per-port state records.
// ----------------------------------------------------------------------------
package gpb_pkg;

  localparam int NUM_PORTS     = 10;  // 1..12
  localparam int PINS_PER_PORT = 16;  // 1..16
  localparam int PORT_AW       = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam logic [15:0] PIN_ALL = 16'((17'd1 << PINS_PER_PORT) - 17'd1);

  // command bit positions
  localparam int CMD_IN     = 0;
  localparam int CMD_OUT    = 1;
  localparam int CMD_OD     = 2;
  localparam int CMD_STORE  = 3;
  localparam int CMD_SET    = 4;
  localparam int CMD_CLEAR  = 5;
  localparam int CMD_INVERT = 6;
  localparam int CMD_POLL   = 7;

  // configuration register indexes
  localparam logic [1:0] CFG_PE_0_3  = 2'd0;
  localparam logic [1:0] CFG_PE_4_7  = 2'd1;
  localparam logic [1:0] CFG_PE_8_11 = 2'd2;
  localparam int         CFG_NUM     = 3;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOR  = 1'b1;

  typedef struct packed {
    logic [3:0]  port_index;
    logic [7:0]  command_bits;
    logic [15:0] pin_mask;
    logic [15:0] pin_levels;
  } gpb_req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] read_value;
    logic [15:0] direction_now;
    logic [15:0] latch_now;
    logic [15:0] open_drain_now;
  } gpb_rsp_t;

  typedef struct packed {
    logic [15:0] dir;
    logic [15:0] lat;
    logic [15:0] od;
  } gpb_state_t;

  localparam int STATE_W = $bits(gpb_state_t);

  localparam gpb_state_t STATE_RESET = '{dir: PIN_ALL, lat: 16'h0000, od: 16'h0000};

endpackage

// ===== hdl/gpb_ram.sv =====
// ----------------------------------------------------------------------------
// gpb_ram - generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gpb_exec.sv =====
// ----------------------------------------------------------------------------
// gpb_exec - masked command update of one port
// Applies in, out/open-drain, store, set, clear, invert and poll in order.
// ----------------------------------------------------------------------------
module gpb_exec
  import gpb_pkg::*;
(
  input  logic [7:0]  cmd,
  input  logic [15:0] arg,
  input  logic [15:0] levels,
  input  logic [15:0] conf,
  input  gpb_state_t  cur,
  output gpb_state_t  nxt,
  output logic [15:0] read_value
);

  logic [15:0] conf_m;
  logic [15:0] mask;
  logic [15:0] dir;
  logic [15:0] lat;
  logic [15:0] od;

  assign conf_m = conf & PIN_ALL;
  assign mask   = arg & conf_m;

  always_comb begin
    dir = cur.dir;
    lat = cur.lat;
    od  = cur.od;
    if (cmd[CMD_IN]) begin
      dir = dir | mask;
    end
    if (cmd[CMD_OUT] || cmd[CMD_OD]) begin
      // output wins over open-drain
      if (cmd[CMD_OUT]) begin
        od = od & ~mask;
      end else begin
        od = od | mask;
      end
      dir = dir & ~mask;
    end
    if (cmd[CMD_STORE]) begin
      lat = (lat & ~conf_m) | mask;
    end
    if (cmd[CMD_SET]) begin
      lat = lat | mask;
    end
    if (cmd[CMD_CLEAR]) begin
      lat = lat & ~mask;
    end
    if (cmd[CMD_INVERT]) begin
      lat = lat ^ mask;
    end
    nxt.dir = dir & PIN_ALL;
    nxt.lat = lat & PIN_ALL;
    nxt.od  = od & PIN_ALL;
  end

  assign read_value = cmd[CMD_POLL]
                    ? (((levels & PIN_ALL & nxt.dir) | (nxt.lat & ~nxt.dir)) & conf_m)
                    : 16'h0000;

endmodule

// ===== hdl/gpio_port_bank_masked_ops.sv =====
// ----------------------------------------------------------------------------
// gpio_port_bank_masked_ops - bank of GPIO ports with masked commands
// Per-port direction, output latch and open-drain bits held in one RAM,
// updated by read-modify-write for each request.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one request per handshake (valid high, stall low at the edge):
//    port, command bits, pin mask and sampled pin levels.
//  - out_*: one response per request, in order: status, poll value and the
//    port's direction, latch and open-drain bits after the update.
//  - cfg_*: write-only; index 0..2 selects the configured-pin mask word
//    (16 bits per port, four ports per word). Other indexes are ignored.
//  - Throughput: one request per cycle while responses are not stalled; the
//    RAM read happens at acceptance, the update and write-back when the
//    update stage hands on its response, and a back-to-back request to the
//    same port takes the written-back state from a forwarding register.
//  - Reset (rst_n low, synchronous) empties the pipeline, clears the masks
//    and marks every RAM entry as never written, so it reads as reset state
//    (all pins input, latches and open-drain clear). No clearing pass.
//  - A stalled response holds in the output register; one further request is
//    taken and waits in the update stage, then in_stall rises.
//  - An out-of-range port leaves state alone and returns status 1, zeros.
// ----------------------------------------------------------------------------
module gpio_port_bank_masked_ops
  import gpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gpb_req_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gpb_rsp_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // configured-pin mask words
  logic [63:0] pe_r [CFG_NUM];

  // update stage
  logic             ex_busy_r;
  gpb_req_t         ex_req_r;
  logic             ex_oor_r;
  logic             ex_fwd_r;      // take state from forwarding register
  logic             ex_ent_vld_r;  // RAM entry written since reset
  gpb_state_t       fwd_state_r;

  // per-entry written flags
  logic [NUM_PORTS-1:0] ent_vld_r;

  // output register
  logic             out_valid_r;
  gpb_rsp_t         out_data_r;

  logic             in_acc;
  logic             ex_done;
  logic             in_range;
  logic [PORT_AW-1:0] in_addr;
  logic [PORT_AW-1:0] ex_addr;
  logic             fwd_hit;
  logic             in_ent_vld;
  logic [STATE_W-1:0] ram_rdata;
  gpb_state_t       cur_state;
  gpb_state_t       new_state;
  logic [15:0]      rd_value;
  logic [15:0]      conf;
  logic [1:0]       conf_word;
  logic [1:0]       conf_sel;
  logic [63:0]      conf_src;
  gpb_rsp_t         rsp;

  // handshakes: update stage frees when the output register can take it
  assign ex_done  = ex_busy_r && (!out_valid_r || !out_stall);
  assign in_stall = ex_busy_r && !ex_done;
  assign in_acc   = in_valid && !in_stall;

  assign in_range = 32'(in_data.port_index) < NUM_PORTS;
  assign in_addr  = PORT_AW'(in_data.port_index);
  assign ex_addr  = PORT_AW'(ex_req_r.port_index);

  // same port written back at this edge: RAM would return stale data
  assign fwd_hit    = ex_done && !ex_oor_r && (ex_req_r.port_index == in_data.port_index);
  assign in_ent_vld = in_range ? ent_vld_r[in_addr] : 1'b0;

  gpb_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_PORTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ex_done && !ex_oor_r),
    .waddr (ex_addr),
    .wdata (new_state),
    .re    (in_acc && in_range),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (ex_fwd_r) begin
      cur_state = fwd_state_r;
    end else if (ex_ent_vld_r) begin
      cur_state = gpb_state_t'(ram_rdata);
    end else begin
      cur_state = STATE_RESET;
    end
  end

  // configured-pin mask of the port in the update stage
  assign conf_word = ex_req_r.port_index[3:2];
  assign conf_sel  = ex_req_r.port_index[1:0];
  assign conf_src  = (32'(conf_word) < CFG_NUM) ? pe_r[conf_word] : 64'h0;
  assign conf      = conf_src[16*conf_sel +: 16];

  gpb_exec u_exec (
    .cmd        (ex_req_r.command_bits),
    .arg        (ex_req_r.pin_mask),
    .levels     (ex_req_r.pin_levels),
    .conf       (conf),
    .cur        (cur_state),
    .nxt        (new_state),
    .read_value (rd_value)
  );

  always_comb begin
    if (ex_oor_r) begin
      rsp = '0;
      rsp.status = STATUS_OOR;
    end else begin
      rsp.status         = STATUS_DONE;
      rsp.read_value     = rd_value;
      rsp.direction_now  = new_state.dir;
      rsp.latch_now      = new_state.lat;
      rsp.open_drain_now = new_state.od;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ent_vld_r   <= '0;
      for (int i = 0; i < CFG_NUM; i++) begin
        pe_r[i] <= 64'h0;
      end
    end else begin
      if (in_acc) begin
        ex_busy_r <= 1'b1;
      end else if (ex_done) begin
        ex_busy_r <= 1'b0;
      end
      if (ex_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ex_done && !ex_oor_r) begin
        ent_vld_r[ex_addr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PE_0_3:  pe_r[0] <= cfg_wdata;
          CFG_PE_4_7:  pe_r[1] <= cfg_wdata;
          CFG_PE_8_11: pe_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_req_r     <= in_data;
      ex_oor_r     <= !in_range;
      ex_fwd_r     <= fwd_hit;
      ex_ent_vld_r <= in_ent_vld;
      fwd_state_r  <= new_state;
    end
    if (ex_done) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/gpb_checker.sv =====
// ----------------------------------------------------------------------------
// gpb_checker - port-level checks of the GPIO port bank
// Watches the request, response and reset behaviour; bound to the top level.
// ----------------------------------------------------------------------------
module gpb_checker
  import gpb_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input gpb_rsp_t out_data
);

  // a held response keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // out-of-range responses carry no state
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_OOR |->
      out_data.read_value == 16'h0 && out_data.direction_now == 16'h0 &&
      out_data.latch_now == 16'h0 && out_data.open_drain_now == 16'h0)
    else $error("out-of-range response not zero");

  // a fresh response traces back to an accepted request
  a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("response without request");

  // requests are only held off behind a stalled response
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with output free");

  // reset empties the response register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind gpio_port_bank_masked_ops gpb_checker u_gpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - GPIO port bank masked operations
// Drives port requests through the valid/stall channel and predicts every
// response from a shadow copy of the per-port pin state and the pin-enable
// masks. Short directed checks come first, then random phases under several
// mask settings. Both channels idle and stall in random bursts, except in the
// last phase; in phase 2 the request side does not idle.
// ----------------------------------------------------------------------------
module testbench;
  import gpb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 210;
  localparam int RANDOM_PHASE = 6;

  // one-hot command words, built from the package bit positions
  localparam logic [7:0] OP_NONE   = 8'h00;
  localparam logic [7:0] OP_IN     = 8'(1 << CMD_IN);
  localparam logic [7:0] OP_OUT    = 8'(1 << CMD_OUT);
  localparam logic [7:0] OP_OD     = 8'(1 << CMD_OD);
  localparam logic [7:0] OP_STORE  = 8'(1 << CMD_STORE);
  localparam logic [7:0] OP_SET    = 8'(1 << CMD_SET);
  localparam logic [7:0] OP_CLEAR  = 8'(1 << CMD_CLEAR);
  localparam logic [7:0] OP_INVERT = 8'(1 << CMD_INVERT);
  localparam logic [7:0] OP_POLL   = 8'(1 << CMD_POLL);
  localparam logic [7:0] OP_ALL    = 8'hff;

  // index above the mask words; the block drops writes to it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  gpb_req_t    in_data;
  logic        out_valid;
  logic        out_stall;
  gpb_rsp_t    out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  gpio_port_bank_masked_ops dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow of the bank: pin-enable words and per-port pin state
  // --------------------------------------------------------------------------
  logic [63:0] pin_enable_shadow [CFG_NUM];
  logic [15:0] dir_shadow        [NUM_PORTS];
  logic [15:0] latch_shadow      [NUM_PORTS];
  logic [15:0] od_shadow         [NUM_PORTS];

  gpb_req_t pending_req_q [$];   // requests waiting for the driver
  gpb_rsp_t expected_rsp_q [$];  // predicted responses, oldest first

  int reqs_queued;
  int reqs_accepted;
  int mismatches;
  int cycle_count;
  int in_gap_pct;
  int out_stall_pct;
  int in_gap_left;
  int out_stall_left;
  logic req_taken;  // request on in_data went in at the last rising edge

  // Applies one request to the shadow state and returns the response the
  // block owes for it. Commands go in fixed order: in, out/open-drain,
  // store, set, clear, invert, then poll on the updated state.
  function automatic gpb_rsp_t predict_port_access(input gpb_req_t r);
    gpb_rsp_t    rsp;
    logic [63:0] word;
    logic [15:0] conf, mask, dir, lat, od, lv;
    rsp = '0;
    if (r.port_index >= NUM_PORTS) begin
      // out of range: nothing moves, everything reads zero
      rsp.status = STATUS_OOR;
      return rsp;
    end
    word = pin_enable_shadow[r.port_index >> 2];
    conf = word[16 * r.port_index[1:0] +: 16] & PIN_ALL;
    mask = r.pin_mask & conf;
    lv   = r.pin_levels & PIN_ALL;
    dir  = dir_shadow[r.port_index];
    lat  = latch_shadow[r.port_index];
    od   = od_shadow[r.port_index];

    if (r.command_bits[CMD_IN])
      dir = dir | mask;
    // out beats open-drain; either one turns the pins into outputs
    if (r.command_bits[CMD_OUT] || r.command_bits[CMD_OD]) begin
      if (r.command_bits[CMD_OUT])
        od = od & ~mask;
      else
        od = od | mask;
      dir = dir & ~mask;
    end
    // store only touches configured pins
    if (r.command_bits[CMD_STORE])
      lat = (lat & ~conf) | mask;
    if (r.command_bits[CMD_SET])
      lat = lat | mask;
    if (r.command_bits[CMD_CLEAR])
      lat = lat & ~mask;
    if (r.command_bits[CMD_INVERT])
      lat = lat ^ mask;

    dir = dir & PIN_ALL;
    lat = lat & PIN_ALL;
    od  = od & PIN_ALL;

    if (r.command_bits[CMD_POLL])
      rsp.read_value = ((lv & dir) | (lat & ~dir)) & conf;

    dir_shadow[r.port_index]   = dir;
    latch_shadow[r.port_index] = lat;
    od_shadow[r.port_index]    = od;

    rsp.status         = STATUS_DONE;
    rsp.direction_now  = dir;
    rsp.latch_now      = lat;
    rsp.open_drain_now = od;
    return rsp;
  endfunction

  task automatic compare_field(input string field_name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: config mirror, response check and request prediction, all on
  // values sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gpb_rsp_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out, %0d responses outstanding", $time,
               expected_rsp_q.size());
      $display("== FAIL ==");
      $finish;
    end
    req_taken <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        dir_shadow[p]   = STATE_RESET.dir;
        latch_shadow[p] = STATE_RESET.lat;
        od_shadow[p]    = STATE_RESET.od;
      end
      for (int w = 0; w < CFG_NUM; w++)
        pin_enable_shadow[w] = '0;
    end else begin
      if (cfg_we && cfg_index < CFG_NUM)
        pin_enable_shadow[cfg_index] = cfg_wdata;

      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: response with nothing expected, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = expected_rsp_q.pop_front();
          compare_field("status", 16'(want.status), 16'(out_data.status));
          compare_field("read_value", want.read_value, out_data.read_value);
          compare_field("direction_now", want.direction_now, out_data.direction_now);
          compare_field("latch_now", want.latch_now, out_data.latch_now);
          compare_field("open_drain_now", want.open_drain_now, out_data.open_drain_now);
        end
      end

      if (in_valid && !in_stall) begin
        expected_rsp_q.push_back(predict_port_access(in_data));
        reqs_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: one request at a time off the pending queue, held while stalled;
  // idle gaps are dropped in between at random
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // stalled: keep the request as it is
    end else if (in_gap_left > 0) begin
      in_valid    <= 1'b0;
      in_gap_left <= in_gap_left - 1;
    end else if (pending_req_q.size() != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid    <= 1'b0;
      in_gap_left <= $urandom_range(0, 2);
    end else if (pending_req_q.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= pending_req_q.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // response back-pressure in random bursts
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall      <= 1'b1;
      out_stall_left <= out_stall_left - 1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_stall      <= 1'b1;
      out_stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_req(input logic [3:0] port, input logic [7:0] cmd,
                           input logic [15:0] mask, input logic [15:0] levels);
    gpb_req_t r;
    r.port_index   = port;
    r.command_bits = cmd;
    r.pin_mask     = mask;
    r.pin_levels   = levels;
    pending_req_q.push_back(r);
    reqs_queued++;
  endtask

  // mask writes only go in with the pipeline empty
  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // waits out every request and response, then the pipeline depth
  task automatic wait_idle();
    while (reqs_accepted != reqs_queued || expected_rsp_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] random_pins();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Ports 0..2 get some three fifths of the traffic so back-to-back requests hit the
  // same port often; a few requests land past the last port.
  function automatic gpb_req_t random_request();
    gpb_req_t r;
    int       sel;
    sel = $urandom_range(0, 99);
    if (sel < 8)
      r.port_index = 4'($urandom_range(NUM_PORTS, 15));
    else if (sel < 55)
      r.port_index = 4'($urandom_range(0, 2));
    else
      r.port_index = 4'($urandom_range(0, NUM_PORTS - 1));
    r.command_bits = 8'($urandom);
    r.pin_mask     = random_pins();
    r.pin_levels   = random_pins();
    return r;
  endfunction

  // mask word for a random phase: all ones, all zeros or random
  function automatic logic [63:0] phase_mask_word(input int phase, input int idx);
    if (phase == 1 || phase == RANDOM_PHASE - 1)
      return '1;
    if (phase == 2 && idx == 0)
      return '0;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PE_0_3;
    cfg_wdata      = '0;
    req_taken      = 1'b0;
    reqs_queued    = 0;
    reqs_accepted  = 0;
    mismatches     = 0;
    cycle_count    = 0;
    in_gap_left    = 0;
    out_stall_left = 0;
    in_gap_pct     = 20;
    out_stall_pct  = 20;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // masks still clear after reset: no pin reacts, polls read zero
    queue_req(4'd0, OP_POLL, 16'hffff, 16'hffff);
    queue_req(4'd3, OP_OUT | OP_SET | OP_POLL, 16'hffff, 16'hffff);
    queue_req(4'd15, OP_ALL, 16'hffff, 16'hffff);
    wait_idle();

    // every pin configured
    write_cfg(CFG_PE_0_3, '1);
    write_cfg(CFG_PE_4_7, '1);
    write_cfg(CFG_PE_8_11, '1);
    write_cfg(CFG_SPARE, 64'h0123_4567_89ab_cdef);

    queue_req(4'd0, OP_OUT, 16'hffff, 16'h0000);
    queue_req(4'd0, OP_STORE | OP_POLL, 16'ha5a5, 16'hffff);
    queue_req(4'd0, OP_SET | OP_POLL, 16'h00ff, 16'h0000);
    queue_req(4'd0, OP_CLEAR | OP_POLL, 16'hf000, 16'h0000);
    queue_req(4'd0, OP_INVERT | OP_POLL, 16'hffff, 16'h0000);
    // input and output together: output wins
    queue_req(4'd0, OP_IN | OP_OUT | OP_POLL, 16'h00ff, 16'h5555);
    queue_req(4'd1, OP_OD, 16'h0f0f, 16'h0000);
    // output and open-drain together: open-drain cleared, pins output
    queue_req(4'd1, OP_OUT | OP_OD | OP_POLL, 16'h00ff, 16'hffff);
    queue_req(4'd1, OP_IN | OP_POLL, 16'hffff, 16'hffff);
    queue_req(4'd5, OP_NONE, 16'hffff, 16'hffff);
    queue_req(4'(NUM_PORTS - 1), OP_ALL, 16'hffff, 16'hffff);
    queue_req(4'(NUM_PORTS - 1), OP_POLL, 16'h0000, 16'h0000);
    queue_req(4'(NUM_PORTS), OP_ALL, 16'hffff, 16'hffff);
    queue_req(4'd2, OP_OUT | OP_SET, 16'hffff, 16'h0000);
    wait_idle();

    // partial masks: store keeps the latch bits of unconfigured pins
    write_cfg(CFG_PE_0_3, 64'h0f0f_f0f0_00ff_ff00);
    queue_req(4'd2, OP_STORE | OP_POLL, 16'h0000, 16'haaaa);
    queue_req(4'd0, OP_STORE | OP_POLL, 16'hffff, 16'h0000);
    queue_req(4'd1, OP_IN | OP_POLL, 16'hffff, 16'h1234);
    queue_req(4'd3, OP_OUT | OP_INVERT | OP_POLL, 16'hffff, 16'hffff);
    wait_idle();

    // random phases, each under its own masks and idling rates; the last
    // runs with every pin configured and no idling on either side
    for (int phase = 0; phase < RANDOM_PHASE; phase++) begin
      write_cfg(CFG_PE_0_3, phase_mask_word(phase, 0));
      write_cfg(CFG_PE_4_7, phase_mask_word(phase, 1));
      write_cfg(CFG_PE_8_11, phase_mask_word(phase, 2));
      if (phase == 3)
        write_cfg(CFG_SPARE, {$urandom, $urandom});
      if (phase == RANDOM_PHASE - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else if (phase == 2) begin
        in_gap_pct    = 0;
        out_stall_pct = 35;
      end else begin
        in_gap_pct    = $urandom_range(10, 40);
        out_stall_pct = $urandom_range(10, 40);
      end
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_req_q.push_back(random_request());
      reqs_queued += PHASE_ITEMS;
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_rsp_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gpb_pkg.sv
hdl/gpb_ram.sv
hdl/gpb_exec.sv
hdl/gpio_port_bank_masked_ops.sv
hdl/gpb_checker.sv
tb/sv/testbench.sv
